FILE: hw/rtl/pwc_pkg.sv
package pwc_pkg;

  // Wall select codes
  localparam logic [1:0] CMD_BOTTOM = 2'd0;
  localparam logic [1:0] CMD_TOP    = 2'd1;
  localparam logic [1:0] CMD_CYL    = 2'd2;

  // Register indexes on the configuration channel
  localparam int unsigned IDX_W = 8;
  localparam logic [IDX_W-1:0] REG_BOX_LEN_X  = 8'd0;
  localparam logic [IDX_W-1:0] REG_BOX_LEN_Y  = 8'd1;
  localparam logic [IDX_W-1:0] REG_BOX_LEN_Z  = 8'd2;
  localparam logic [IDX_W-1:0] REG_CYL_RADIUS = 8'd3;

  localparam logic [62:0] SQ_MAX = {63{1'b1}};

  typedef struct packed {
    logic [30:0] box_len_x;
    logic [30:0] box_len_y;
    logic [30:0] box_len_z;
    logic [30:0] cyl_radius;
  } cfg_regs_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic [1:0]  command;
    logic        plane_contact;
    logic [31:0] offset_z;
    logic [31:0] dmag;
    logic [31:0] ax;
    logic [31:0] ay;
    logic        nx;
    logic        ny;
    logic [30:0] particle_radius;
  } item_t;

endpackage

FILE: hw/rtl/pwc_if.sv
interface pwc_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [30:0]        particle_radius;

  modport source(output valid, command, pos_x, pos_y, pos_z, particle_radius, input ready);
  modport sink(input valid, command, pos_x, pos_y, pos_z, particle_radius, output ready);
endinterface

interface pwc_rsp_if;
  logic               valid;
  logic               ready;
  logic               contact;
  logic               degenerate;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  logic signed [31:0] offset_z;
  logic [62:0]        offset_sq;

  modport source(output valid, contact, degenerate, offset_x, offset_y, offset_z, offset_sq,
                 input ready);
  modport sink(input valid, contact, degenerate, offset_x, offset_y, offset_z, offset_sq,
               output ready);
endinterface

interface pwc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [30:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: hw/rtl/pwc_front.sv
module pwc_front import pwc_pkg::*; (
  pwc_req_if.sink  req,
  input  cfg_regs_t regs,
  output logic      push_valid,
  input  logic      push_ready,
  output item_t     push_data
);

  logic signed [33:0] pz, rad, boxz, top_sum, dz, dx, dy;
  logic               bottom_hit, top_hit;
  logic [31:0]        d;
  logic [33:0]        mx, my;

  assign req.ready  = push_ready;
  assign push_valid = req.valid;

  always_comb begin
    pz      = {{2{req.pos_z[31]}}, req.pos_z};
    rad     = {3'b000, req.particle_radius};
    boxz    = {3'b000, regs.box_len_z};
    top_sum = pz + rad;
    dz      = pz - boxz;
    bottom_hit = pz < rad;
    top_hit    = top_sum > boxz;

    // Offset from the cylinder axis
    dx = {{2{req.pos_x[31]}}, req.pos_x} - {4'b0000, regs.box_len_x[30:1]};
    dy = {{2{req.pos_y[31]}}, req.pos_y} - {4'b0000, regs.box_len_y[30:1]};
    mx = dx[33] ? 34'(-dx) : 34'(dx);
    my = dy[33] ? 34'(-dy) : 34'(dy);

    push_data = '0;
    push_data.command         = req.command;
    push_data.particle_radius = req.particle_radius;
    push_data.ax = mx[31:0];
    push_data.ay = my[31:0];
    push_data.nx = dx[33];
    push_data.ny = dy[33];

    d = 32'd0;
    case (req.command)
      CMD_BOTTOM: begin
        push_data.plane_contact = bottom_hit;
        d = req.pos_z;
      end
      CMD_TOP: begin
        push_data.plane_contact = top_hit;
        d = dz[31:0];
      end
      default: begin
        push_data.plane_contact = 1'b0;
      end
    endcase
    if (!push_data.plane_contact) begin
      d = 32'd0;
    end
    push_data.offset_z = d;
    push_data.dmag     = d[31] ? 32'(-d) : d;
  end

endmodule

FILE: hw/rtl/pwc_queue.sv
module pwc_queue import pwc_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_data
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  item_t           mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            push, pop;

  assign push_ready = count != CntW'(Depth);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/pwc_back.sv
module pwc_back import pwc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [30:0] cyl_radius,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  item_t       pop_data,
  pwc_rsp_if.source   rsp
);

  localparam int SQ_FIRST  = 2;   // first square-root step, root bit 32
  localparam int SQ_LAST   = 34;
  localparam int ST_CMP    = 35;
  localparam int ST_PROD   = 36;
  localparam int DV_FIRST  = 37;  // first divide step, quotient bit 32
  localparam int DV_LAST   = 69;
  localparam int ST_SQR    = 70;
  localparam int NS        = 72;

  typedef struct packed {
    logic [1:0]  command;
    logic        plane_contact;
    logic [31:0] offset_z;
    logic [31:0] ax;
    logic [31:0] ay;
    logic        nx;
    logic        ny;
    logic [30:0] rad;
    logic [63:0] sqx;
    logic [63:0] sqy;
    logic [65:0] radicand;
    logic [32:0] root;
    logic [35:0] srem;
    logic        contact;
    logic        in_cyl;
    logic        degenerate;
    logic [32:0] gap;
    logic [64:0] prodx;
    logic [64:0] prody;
    logic [33:0] remx;
    logic [33:0] remy;
    logic [32:0] qx;
    logic [32:0] qy;
    logic        big;
    logic [31:0] off_x;
    logic [31:0] off_y;
    logic [62:0] osq;
  } pipe_t;

  pipe_t          pipe [NS];
  pipe_t          pipe_next [NS];
  pipe_t          head;
  logic [NS-1:0]  vld;
  logic           advance;

  function automatic logic [31:0] sat32(input logic [32:0] mag, input logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (mag > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(-mag[31:0]);
    end else begin
      r = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return r;
  endfunction

  function automatic pipe_t stage_fn(input int k, input pipe_t p, input logic [30:0] cyl);
    pipe_t       n;
    logic [35:0] t, trial;
    logic [33:0] tx, ty, dv;
    logic [33:0] reach;
    logic [64:0] sum;
    int          i;
    n = p;
    if (k == 0) begin
      n.sqx = 64'(p.ax) * 64'(p.ax);
      n.sqy = 64'(p.ay) * 64'(p.ay);
    end else if (k == 1) begin
      n.radicand = 66'(p.sqx) + 66'(p.sqy);
      n.osq      = p.sqx[62:0];
      n.root     = '0;
      n.srem     = '0;
    end else if (k <= SQ_LAST) begin
      // One root bit per stage, restoring method
      i     = SQ_LAST - k;
      t     = {p.srem[33:0], p.radicand[2*i+1 -: 2]};
      trial = {1'b0, p.root, 2'b01};
      if (t >= trial) begin
        n.srem = t - trial;
        n.root = {p.root[31:0], 1'b1};
      end else begin
        n.srem = t;
        n.root = {p.root[31:0], 1'b0};
      end
    end else if (k == ST_CMP) begin
      reach        = {1'b0, p.root} + {3'b000, p.rad};
      n.contact    = reach > {3'b000, cyl};
      n.in_cyl     = p.root < {2'b00, cyl};
      n.gap        = n.in_cyl ? {2'b00, cyl} - p.root : p.root - {2'b00, cyl};
      n.degenerate = p.root == '0;
    end else if (k == ST_PROD) begin
      n.prodx = 65'(p.ax) * 65'(p.gap);
      n.prody = 65'(p.ay) * 65'(p.gap);
      n.remx  = {1'b0, n.prodx[64:32]} >> 1;
      n.remy  = {1'b0, n.prody[64:32]} >> 1;
      n.qx    = '0;
      n.qy    = '0;
    end else if (k <= DV_LAST) begin
      // One quotient bit per stage for each axis
      i  = DV_LAST - k;
      dv = {1'b0, p.root};
      tx = {p.remx[32:0], p.prodx[i]};
      ty = {p.remy[32:0], p.prody[i]};
      n.remx = (tx >= dv) ? tx - dv : tx;
      n.remy = (ty >= dv) ? ty - dv : ty;
      n.qx   = {p.qx[31:0], tx >= dv};
      n.qy   = {p.qy[31:0], ty >= dv};
    end else if (k == ST_SQR) begin
      n.big   = p.qx[32] | p.qy[32];
      n.sqx   = 64'(p.qx[31:0]) * 64'(p.qx[31:0]);
      n.sqy   = 64'(p.qy[31:0]) * 64'(p.qy[31:0]);
      n.off_x = sat32(p.qx, (p.qx != '0) && (p.nx != p.in_cyl));
      n.off_y = sat32(p.qy, (p.qy != '0) && (p.ny != p.in_cyl));
    end else begin
      sum = 65'(p.sqx) + 65'(p.sqy);
      if (p.command == CMD_CYL) begin
        n.offset_z = '0;
        n.osq      = (p.big || sum[64] || sum[63]) ? SQ_MAX : sum[62:0];
        if (p.degenerate || !p.contact) begin
          n.off_x = '0;
          n.off_y = '0;
          n.osq   = '0;
        end
      end else begin
        n.contact    = p.plane_contact;
        n.degenerate = 1'b0;
        n.off_x      = '0;
        n.off_y      = '0;
        if (!p.plane_contact) begin
          n.osq = '0;
        end
      end
    end
    return n;
  endfunction

  always_comb begin
    head = '0;
    head.command       = pop_data.command;
    head.plane_contact = pop_data.plane_contact;
    head.offset_z      = pop_data.offset_z;
    head.ax            = (pop_data.command == CMD_CYL) ? pop_data.ax : pop_data.dmag;
    head.ay            = (pop_data.command == CMD_CYL) ? pop_data.ay : 32'd0;
    head.nx            = pop_data.nx;
    head.ny            = pop_data.ny;
    head.rad           = pop_data.particle_radius;
    pipe_next[0] = stage_fn(0, head, cyl_radius);
    for (int k = 1; k < NS; k++) begin
      pipe_next[k] = stage_fn(k, pipe[k-1], cyl_radius);
    end
  end

  // Whole pipeline moves together; it holds only while the result waits
  assign advance   = !vld[NS-1] || rsp.ready;
  assign pop_ready = advance;

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < NS; k++) begin
        pipe[k] <= pipe_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[NS-2:0], pop_valid};
    end
  end

  assign rsp.valid      = vld[NS-1];
  assign rsp.contact    = pipe[NS-1].contact;
  assign rsp.degenerate = pipe[NS-1].degenerate;
  assign rsp.offset_x   = pipe[NS-1].off_x;
  assign rsp.offset_y   = pipe[NS-1].off_y;
  assign rsp.offset_z   = pipe[NS-1].offset_z;
  assign rsp.offset_sq  = pipe[NS-1].osq;

`ifndef SYNTHESIS
  a_no_contact_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.contact |-> rsp.offset_x == 0 && rsp.offset_y == 0 &&
      rsp.offset_z == 0 && rsp.offset_sq == 0)
    else $error("offset without contact");
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.degenerate |-> rsp.offset_x == 0 && rsp.offset_y == 0 &&
      rsp.offset_sq == 0)
    else $error("degenerate result carries an offset");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !advance |=> vld == $past(vld))
    else $error("pipeline moved while stalled");
`endif

endmodule

FILE: hw/rtl/particle_wall_contact_core.sv
// Throughput: one item per cycle while results are taken; a pipelined square
// root (33 stages, one root bit each) and a pipelined divider (33 stages, one
// quotient bit each) set the depth.
// Reset (rst, synchronous, active high) clears the wall registers to zero,
// empties the queue and drops every item in flight.
module particle_wall_contact_core import pwc_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic     clk,
  input  logic     rst,
  pwc_req_if.sink  req,
  pwc_rsp_if.source rsp,
  pwc_cfg_if.sink  cfg
);

  cfg_regs_t regs;
  logic      push_valid, push_ready;
  item_t     push_data;
  logic      pop_valid, pop_ready;
  item_t     pop_data;

  // Registers take every transfer; an unknown index is dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_BOX_LEN_X:  regs.box_len_x  <= cfg.data;
        REG_BOX_LEN_Y:  regs.box_len_y  <= cfg.data;
        REG_BOX_LEN_Z:  regs.box_len_z  <= cfg.data;
        REG_CYL_RADIUS: regs.cyl_radius <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Front: classify the wall, finish plane tests, form axis offsets
  pwc_front u_front (
    .req        (req),
    .regs       (regs),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Short queue so the front keeps taking items while the back holds
  pwc_queue #(.Depth(QueueDepth)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: squares, square root, contact, scaling divide, saturation
  pwc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cyl_radius (regs.cyl_radius),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .rsp        (rsp)
  );

endmodule

FILE: tb/tb_particle_wall_contact_core.sv
`timescale 1ns / 1ps

module tb_particle_wall_contact_core;
  import pwc_pkg::*;

  // Command with no wall behind it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // One expected contact report, held in arrival order
  typedef struct {
    bit        contact;
    bit        degenerate;
    bit [31:0] offset_x;
    bit [31:0] offset_y;
    bit [31:0] offset_z;
    bit [62:0] offset_sq;
  } contact_report_t;

  logic clk;
  logic rst;

  pwc_req_if req_if ();
  pwc_rsp_if rsp_if ();
  pwc_cfg_if cfg_if ();

  particle_wall_contact_core DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  // Local copy of the wall registers
  bit [30:0] wall_len_x, wall_len_y, wall_len_z, wall_cyl_r;

  contact_report_t pending_reports[$];
  int unsigned fail_count;
  int unsigned reports_seen;
  int unsigned contacts_seen;
  int unsigned degen_seen;
  int unsigned items_sent;

  // Sender burst state and receiver stall controls
  int unsigned burst_left;
  int unsigned hold_off_cycles;
  int unsigned stall_level;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Saturate a magnitude with a sign to the signed 32-bit range
  function automatic bit [31:0] clamp_s32(bit [127:0] mag, bit neg);
    if (neg) begin
      if (mag > 128'h8000_0000) return 32'h8000_0000;
      return -mag[31:0];
    end
    if (mag > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  // Work out the contact report for one particle against the selected wall
  function automatic contact_report_t wall_contact(bit [1:0] cmd, bit [31:0] px, bit [31:0] py,
                                                  bit [31:0] pz, bit [30:0] rad);
    contact_report_t r;
    longint sz, srad, d, dx, dy;
    bit [127:0] ax, ay, sum, cand, mx, my, sq;
    bit [63:0] root, gap, m;
    bit in_cyl;
    r = '{default: '0};
    sz = longint'($signed(pz));
    srad = longint'({1'b0, rad});
    if (cmd == CMD_BOTTOM || cmd == CMD_TOP) begin
      if (cmd == CMD_BOTTOM && sz < srad) begin
        r.contact = 1'b1;
        d = sz;
      end else if (cmd == CMD_TOP && sz + srad > longint'({1'b0, wall_len_z})) begin
        r.contact = 1'b1;
        d = sz - longint'({1'b0, wall_len_z});
      end
      if (r.contact) begin
        m = (d < 0) ? -d : d;
        r.offset_z = d[31:0];
        sq = 128'(m) * 128'(m);
        r.offset_sq = sq[62:0];
      end
    end else if (cmd == CMD_CYL) begin
      dx = longint'($signed(px)) - longint'(wall_len_x >> 1);
      dy = longint'($signed(py)) - longint'(wall_len_y >> 1);
      ax = 128'(64'((dx < 0) ? -dx : dx));
      ay = 128'(64'((dy < 0) ? -dy : dy));
      sum = ax * ax + ay * ay;
      root = 0;
      for (int b = 32; b >= 0; b--) begin
        cand = 128'(root | (64'd1 << b));
        if (cand * cand <= sum) root = cand[63:0];
      end
      if (root + 64'(rad) > 64'(wall_cyl_r)) r.contact = 1'b1;
      if (root == 0) begin
        r.degenerate = 1'b1;
      end else if (r.contact) begin
        in_cyl = root < 64'(wall_cyl_r);
        gap = in_cyl ? 64'(wall_cyl_r) - root : root - 64'(wall_cyl_r);
        mx = (ax * 128'(gap)) / 128'(root);
        my = (ay * 128'(gap)) / 128'(root);
        r.offset_x = clamp_s32(mx, mx != 0 && ((dx < 0) != in_cyl));
        r.offset_y = clamp_s32(my, my != 0 && ((dy < 0) != in_cyl));
        sq = mx * mx + my * my;
        r.offset_sq = (sq > 128'(SQ_MAX)) ? SQ_MAX : sq[62:0];
      end
    end
    return r;
  endfunction

  // Receiver: long hold-off when asked, else stall on a random pattern
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_off_cycles != 0) begin
      rsp_if.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 9) >= stall_level);
    end
  end

  // Compare each transfer on the result channel with the oldest expectation
  always @(posedge clk) begin
    contact_report_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_reports.size() == 0) begin
        $error("result with no pending expectation");
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        reports_seen++;
        if (want.contact) contacts_seen++;
        if (want.degenerate) degen_seen++;
        if (rsp_if.contact !== want.contact) begin
          $error("contact: expected %0d, got %0d", want.contact, rsp_if.contact);
          fail_count++;
        end
        if (rsp_if.degenerate !== want.degenerate) begin
          $error("degenerate: expected %0d, got %0d", want.degenerate, rsp_if.degenerate);
          fail_count++;
        end
        if (rsp_if.offset_x !== want.offset_x) begin
          $error("offset_x: expected %h, got %h", want.offset_x, rsp_if.offset_x);
          fail_count++;
        end
        if (rsp_if.offset_y !== want.offset_y) begin
          $error("offset_y: expected %h, got %h", want.offset_y, rsp_if.offset_y);
          fail_count++;
        end
        if (rsp_if.offset_z !== want.offset_z) begin
          $error("offset_z: expected %h, got %h", want.offset_z, rsp_if.offset_z);
          fail_count++;
        end
        if (rsp_if.offset_sq !== want.offset_sq) begin
          $error("offset_sq: expected %h, got %h", want.offset_sq, rsp_if.offset_sq);
          fail_count++;
        end
      end
    end
  end

  // Offer one particle; hold it until the transfer, then record its expectation
  task automatic send_particle(bit [1:0] cmd, bit [31:0] px, bit [31:0] py, bit [31:0] pz,
                               bit [30:0] rad);
    int unsigned idle_cycles;
    if (burst_left == 0) begin
      idle_cycles = $urandom_range(0, 6);
      if (idle_cycles != 0) begin
        req_if.valid <= 1'b0;
        repeat (idle_cycles) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    req_if.valid <= 1'b1;
    req_if.command <= cmd;
    req_if.pos_x <= px;
    req_if.pos_y <= py;
    req_if.pos_z <= pz;
    req_if.particle_radius <= rad;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_reports.push_back(wall_contact(cmd, px, py, pz, rad));
    items_sent++;
    burst_left--;
  endtask

  // Drop valid, drain the pipeline, then allow the full latency to pass
  task automatic drain_pipeline();
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(bit [7:0] idx, bit [30:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_BOX_LEN_X: wall_len_x = value;
      REG_BOX_LEN_Y: wall_len_y = value;
      REG_BOX_LEN_Z: wall_len_z = value;
      REG_CYL_RADIUS: wall_cyl_r = value;
      default: ;
    endcase
  endtask

  task automatic set_walls(bit [30:0] lx, bit [30:0] ly, bit [30:0] lz, bit [30:0] cr);
    drain_pipeline();
    write_reg(REG_BOX_LEN_X, lx);
    write_reg(REG_BOX_LEN_Y, ly);
    write_reg(REG_BOX_LEN_Z, lz);
    write_reg(REG_CYL_RADIUS, cr);
  endtask

  // Plane extremes, unused command, all at the reset walls and then a real box
  task automatic test_plane_extremes();
    send_particle(CMD_BOTTOM, 32'h0, 32'h0, 32'h8000_0000, 31'h7FFF_FFFF);
    send_particle(CMD_BOTTOM, 32'h0, 32'h0, 32'h0, 31'h0);
    send_particle(CMD_BOTTOM, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_particle(CMD_TOP, 32'h0, 32'h0, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_particle(CMD_TOP, 32'h0, 32'h0, 32'h8000_0000, 31'h0);
    send_particle(CMD_UNUSED, 32'h1234_5678, 32'h8765_4321, 32'h0, 31'h7FFF_FFFF);
    set_walls(31'h0014_0000, 31'h0014_0000, 31'h0010_0000, 31'h0008_0000);
    send_particle(CMD_BOTTOM, 32'h0, 32'h0, 32'h0000_8000, 31'h0001_0000);
    send_particle(CMD_TOP, 32'h0, 32'h0, 32'h000F_8000, 31'h0001_0000);
    send_particle(CMD_TOP, 32'h0, 32'h0, 32'h000F_0000, 31'h0001_0000);
    send_particle(CMD_UNUSED, 32'h0, 32'h0, 32'h0, 31'h0);
    // Ignored index: the registers must stay as they are
    drain_pipeline();
    write_reg(8'd7, 31'h7FFF_FFFF);
    write_reg(8'hFF, 31'h1);
  endtask

  // Centre on the axis, far outside, inside touching, inside clear
  task automatic test_cylinder_cases();
    send_particle(CMD_CYL, 32'h000A_0000, 32'h000A_0000, 32'h0, 31'h0);
    send_particle(CMD_CYL, 32'h000A_0000, 32'h000A_0000, 32'h0, 31'h7FFF_FFFF);
    send_particle(CMD_CYL, 32'h8000_0000, 32'h8000_0000, 32'h0, 31'h0);
    send_particle(CMD_CYL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 31'h0);
    send_particle(CMD_CYL, 32'h0011_0000, 32'h000A_0000, 32'h0, 31'h0002_0000);
    send_particle(CMD_CYL, 32'h0003_0000, 32'h000A_0000, 32'h0, 31'h0002_0000);
    send_particle(CMD_CYL, 32'h000B_0000, 32'h000C_0000, 32'h0, 31'h0001_0000);
    send_particle(CMD_CYL, 32'h000C_0000, 32'h000E_0000, 32'h0, 31'h0004_0000);
    set_walls(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_particle(CMD_CYL, 32'h3FFF_FFFF, 32'h3FFF_FFFF, 32'h0, 31'h0);
    send_particle(CMD_CYL, 32'h8000_0000, 32'h8000_0000, 32'h0, 31'h7FFF_FFFF);
    send_particle(CMD_TOP, 32'h0, 32'h0, 32'h7FFF_FFFF, 31'h1);
  endtask

  // Mostly particles near the chosen wall, some anywhere, a few unused commands
  task automatic test_random_particles(int unsigned count);
    bit [1:0] cmd;
    bit [31:0] px, py, pz;
    bit [30:0] rad;
    longint cx, cy, span;
    for (int unsigned n = 0; n < count; n++) begin
      cmd = ($urandom_range(0, 19) == 0) ? CMD_UNUSED : 2'($urandom_range(0, 2));
      px = $urandom;
      py = $urandom;
      pz = $urandom;
      rad = 31'($urandom);
      if ($urandom_range(0, 3) != 0) begin
        rad = 31'($urandom_range(0, 32'h0004_0000));
        span = longint'(wall_cyl_r) + longint'(rad) + 64'h1_0000;
        cx = longint'(wall_len_x >> 1);
        cy = longint'(wall_len_y >> 1);
        px = 32'(cx - span + longint'($urandom_range(0, 32'(2 * span))));
        py = 32'(cy - span + longint'($urandom_range(0, 32'(2 * span))));
        if (cmd == CMD_BOTTOM)
          pz = 32'(longint'(rad) - 64'h2_0000 + longint'($urandom_range(0, 32'h4_0000)));
        else if (cmd == CMD_TOP)
          pz = 32'(longint'(wall_len_z) - longint'(rad) - 64'h2_0000
                   + longint'($urandom_range(0, 32'h4_0000)));
        if ($urandom_range(0, 15) == 0) begin
          px = 32'(cx);
          py = 32'(cy);
        end
      end
      send_particle(cmd, px, py, pz, rad);
    end
  endtask

  // Hold the receiver off long enough that the block fills and stalls its input
  task automatic test_backpressure();
    drain_pipeline();
    hold_off_cycles = 300;
    burst_left = 200;
    test_random_particles(120);
  endtask

  initial begin
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.command = CMD_BOTTOM;
    req_if.pos_x = '0;
    req_if.pos_y = '0;
    req_if.pos_z = '0;
    req_if.particle_radius = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    wall_len_x = '0;
    wall_len_y = '0;
    wall_len_z = '0;
    wall_cyl_r = '0;
    fail_count = 0;
    reports_seen = 0;
    contacts_seen = 0;
    degen_seen = 0;
    items_sent = 0;
    burst_left = 0;
    hold_off_cycles = 0;
    stall_level = 3;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_plane_extremes();
    test_cylinder_cases();

    // Sweep wall settings: tiny, typical, odd lengths, full scale, and large
    set_walls(31'h0, 31'h0, 31'h0, 31'h0);
    stall_level = 0;
    test_random_particles(80);
    set_walls(31'h0014_0000, 31'h0020_0000, 31'h0030_0000, 31'h0009_8000);
    stall_level = 5;
    test_random_particles(120);
    set_walls(31'h0000_0003, 31'h0012_3457, 31'h0000_0001, 31'h0000_0002);
    stall_level = 2;
    test_random_particles(60);
    set_walls(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    stall_level = 8;
    test_random_particles(60);
    set_walls(31'h0100_0000, 31'h0100_0000, 31'h0200_0000, 31'h0040_0000);
    stall_level = 3;
    test_random_particles(80);
    test_backpressure();

    drain_pipeline();
    $display("sent %0d particles, checked %0d reports", items_sent, reports_seen);
    $display("reports with contact %0d, centred on axis %0d", contacts_seen, degen_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

endmodule
